// ----- rtl/indexed_insert_remove_list_defines.svh -----
// Assertion macros shared by the checker of the indexed insert/remove list.
`ifndef INDEXED_INSERT_REMOVE_LIST_DEFINES_SVH
`define INDEXED_INSERT_REMOVE_LIST_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IIRL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define IIRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/iirl_pkg.sv -----
// Types and codes shared by the indexed insert/remove list modules.
`timescale 1ns / 1ps

package iirl_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_NULL  = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   // Broadcast to every cell for one accepted item.
   typedef struct packed {
      logic        ins;
      logic        rem;
      logic [7:0]  pos;
      logic [31:0] word;
   } cell_ctrl_type;

endpackage

// ----- rtl/iirl_cell.sv -----
// One list place: holds an entry and shifts with its neighbors.
`timescale 1ns / 1ps

module iirl_cell #(
   parameter int IDX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  iirl_pkg::cell_ctrl_type ctrl,
   input  logic [31:0]             left_word,
   input  logic [31:0]             right_word,
   output logic [31:0]             word,
   output logic [31:0]             tap
);
   import iirl_pkg::*;

   localparam logic [7:0] MY_IDX = 8'(IDX);

   logic [31:0] word_ff;
   logic [31:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctrl.ins) begin
         if (MY_IDX == ctrl.pos) begin
            word_in = ctrl.word;
         end else if (MY_IDX > ctrl.pos) begin
            word_in = left_word;
         end
      end else if (ctrl.rem) begin
         if (MY_IDX >= ctrl.pos) begin
            word_in = right_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign word = word_ff;
   assign tap  = (MY_IDX == ctrl.pos) ? word_ff : '0;

endmodule

// ----- rtl/indexed_insert_remove_list.sv -----
// Top level of the indexed insert/remove list.
// Usage:
//  - Request channel: drive req_opcode, req_position and req_data_word with
//    start high; the item is taken at the clock edge where busy is low.
//    Opcodes: insert at index, append at end, remove at index.
//  - Response channel: one item per request, shown for exactly one cycle
//    with rsp_valid high, in the cycle after the request is taken. The
//    receiver cannot stall it; it must sample in that cycle.
//  - Throughput: one request per cycle while busy is low. Every list place
//    is a cell that loads from its left or right neighbor in the same edge,
//    so the whole list shifts together; the removed entry comes from the
//    cell taps, ORed at the top.
//  - Status: ok, index out of range, null data word, or list full. A
//    rejected request leaves the list unchanged; rsp_count is the entry
//    count after the request.
//  - Reset (synchronous): clears all cells and the count. busy is high while
//    reset is high and in the cycle after.
`timescale 1ns / 1ps

module indexed_insert_remove_list #(
   parameter int ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_position,
   input  logic [31:0] req_data_word,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_removed_word,
   output logic [7:0]  rsp_count
);
   import iirl_pkg::*;

   localparam logic [7:0] CAP = 8'(ENTRIES);

   logic          busy_ff;
   logic [7:0]    count_ff;
   logic [7:0]    count_in;
   logic          valid_ff;
   logic [1:0]    status_ff;
   logic [31:0]   removed_ff;
   logic [7:0]    rsp_count_ff;

   logic          accept;
   logic [1:0]    status;
   logic [31:0]   taken;
   cell_ctrl_type ctrl;

   logic [31:0] words [ENTRIES];
   logic [31:0] taps  [ENTRIES];

   assign busy   = reset | busy_ff;
   assign accept = start & ~busy;

   always_comb begin
      status = ST_OK;
      if (req_opcode == OP_INSERT || req_opcode == OP_APPEND) begin
         if (req_opcode == OP_INSERT && req_position > count_ff) begin
            status = ST_RANGE;
         end else if (req_data_word == '0) begin
            status = ST_NULL;
         end else if (count_ff >= CAP) begin
            status = ST_FULL;
         end
      end else if (req_opcode == OP_REMOVE) begin
         if (req_position >= count_ff) begin
            status = ST_RANGE;
         end
      end
   end

   always_comb begin
      ctrl.ins  = accept && status == ST_OK &&
                  (req_opcode == OP_INSERT || req_opcode == OP_APPEND);
      ctrl.rem  = accept && status == ST_OK && req_opcode == OP_REMOVE;
      ctrl.pos  = (req_opcode == OP_APPEND) ? count_ff : req_position;
      ctrl.word = req_data_word;
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + 8'd1;
      end else if (ctrl.rem) begin
         count_in = count_ff - 8'd1;
      end
   end

   // Only the addressed cell drives a nonzero tap.
   always_comb begin
      taken = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         taken = taken | taps[i];
      end
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      logic [31:0] left_w;
      logic [31:0] right_w;
      if (g == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = words[g-1];
      end
      if (g == ENTRIES - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = words[g+1];
      end
      iirl_cell #(.IDX(g)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_word  (left_w),
         .right_word (right_w),
         .word       (words[g]),
         .tap        (taps[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= 1'b0;
         count_ff <= count_in;
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status;
         removed_ff   <= ctrl.rem ? taken : '0;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_removed_word = removed_ff;
   assign rsp_count        = rsp_count_ff;

endmodule

// ----- rtl/iirl_checker.sv -----
// Port-level checker for the indexed insert/remove list, with its bind.
`timescale 1ns / 1ps
`include "indexed_insert_remove_list_defines.svh"

module iirl_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_removed_word,
   input logic [7:0]  rsp_count
);
   import iirl_pkg::*;

   `IIRL_ASSERT_NEXT(a_rsp_follows, clock, reset, start && !busy, rsp_valid, "missing response")
   `IIRL_ASSERT_NEXT(a_no_spurious, clock, reset, !(start && !busy), !rsp_valid, "extra response")
   `IIRL_ASSERT_SAME(a_reject_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_removed_word == 32'd0, "rejected item returned a word")
   `IIRL_ASSERT_SAME(a_reject_hold, clock, reset, rsp_valid && $past(rsp_valid) && rsp_status != ST_OK, rsp_count == $past(rsp_count), "rejected item changed count")

endmodule

bind indexed_insert_remove_list iirl_checker u_iirl_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_removed_word (rsp_removed_word),
   .rsp_count        (rsp_count)
);
